/* rtl/core/mps_pkg.sv */
package mps_pkg;

  localparam int unsigned DelimWordW   = 64;
  localparam int unsigned DelimWords   = 4;
  localparam int unsigned DelimBitsW   = DelimWordW * DelimWords;
  localparam int unsigned DelimLenW    = 6;
  localparam int unsigned CfgIndexW    = 3;
  localparam int unsigned OffsetW      = 32;
  localparam logic [7:0]  CR_BYTE      = 8'h0D;
  localparam logic [DelimLenW-1:0] DelimLenReset = DelimLenW'(1);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_DELIM_WORD0  = 3'd0,
    CFG_DELIM_WORD1  = 3'd1,
    CFG_DELIM_WORD2  = 3'd2,
    CFG_DELIM_WORD3  = 3'd3,
    CFG_DELIM_LENGTH = 3'd4
  } cfg_index_e;

  typedef enum logic {
    REQ_BODY_BYTE = 1'b0,
    REQ_END_OF_MSG = 1'b1
  } req_type_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] body_byte;
  } req_t;

  typedef struct packed {
    logic               out_valid;
    logic [7:0]         out_byte;
    logic               field_done;
    logic               delim_seen;
    logic [OffsetW-1:0] byte_offset;
  } res_t;

  typedef struct packed {
    logic [DelimBitsW-1:0] delim;
    logic [DelimLenW-1:0]  delim_length;
    logic                  clear;
  } cfg_t;

endpackage

/* rtl/core/mps_if.sv */
interface mps_req_if import mps_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] body_byte;

  modport source (output valid, output req_type, output body_byte, input ready);
  modport sink   (input valid, input req_type, input body_byte, output ready);
endinterface

interface mps_res_if import mps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               field_done;
  logic               delim_seen;
  logic [OffsetW-1:0] byte_offset;

  modport source (output valid, output out_valid, output out_byte, output field_done,
                  output delim_seen, output byte_offset, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input field_done,
                  input delim_seen, input byte_offset, output ready);
endinterface

interface mps_cfg_if import mps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CfgIndexW-1:0]  index;
  logic [DelimWordW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/multipart_boundary_scanner.sv */
// Multipart boundary scanner: takes one body byte or end-of-message transaction per cycle
// while the result output is not stalled, and searches the field body for the delimiter
// held in delim_word0..3 / delim_length (1 to MAX_DELIM bytes, zero treated as one). Data
// bytes pass an input register, the scan and a result register; a byte is held back while
// it may still start a delimiter, optionally behind a carriage return, and released once
// that is ruled out. A delimiter match gives field_done with delim_seen and drops a
// carriage return just before it; end of message discards held bytes and gives field_done
// alone. Sustained rate is one transaction per cycle while the receiver is ready, set by the
// combinational parallel window compare feeding the hold-window registers. Configuration
// writes clear the window and must only be issued while the block is idle.
module multipart_boundary_scanner import mps_pkg::*; #(
  parameter int unsigned MAX_DELIM = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mps_req_if.sink   req_i,
  mps_res_if.source res_o,
  mps_cfg_if.sink   cfg_i
);

  req_t req_q;
  logic req_vld_q;
  res_t res_q;
  logic res_vld_q;
  logic adv, fire, has_res;
  res_t scan_res;
  cfg_t cfg;

  assign adv         = !res_vld_q || res_o.ready;
  assign fire        = req_vld_q && adv;
  assign req_i.ready = !req_vld_q || adv;
  assign cfg_i.ready = 1'b1;

  mps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid && cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  mps_scan #(.MAX_DELIM(MAX_DELIM)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_i     (req_q),
    .cfg_i     (cfg),
    .has_res_o (has_res),
    .res_o     (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        req_vld_q <= 1'b1;
      end else if (fire) begin
        req_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= fire && has_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.req_type  <= req_i.req_type;
      req_q.body_byte <= req_i.body_byte;
    end
    if (fire && has_res) begin
      res_q <= scan_res;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.out_valid   = res_q.out_valid;
  assign res_o.out_byte    = res_q.out_byte;
  assign res_o.field_done  = res_q.field_done;
  assign res_o.delim_seen  = res_q.delim_seen;
  assign res_o.byte_offset = res_q.byte_offset;

  a_no_drop_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && !adv) |=> req_vld_q)
    else $error("pending transaction lost while output stalled");

  a_result_ends_or_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_q.out_valid || res_q.field_done))
    else $error("empty result presented");

  a_seen_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.delim_seen) |-> res_q.field_done)
    else $error("delimiter flag without field end");

endmodule

/* rtl/core/mps_cfg_regs.sv */
module mps_cfg_regs import mps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CfgIndexW-1:0]  wr_index_i,
  input  logic [DelimWordW-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  logic [DelimWordW-1:0] word_q [DelimWords];
  logic [DelimLenW-1:0]  len_q;
  logic                  known_idx;

  always_comb begin
    case (cfg_index_e'(wr_index_i))
      CFG_DELIM_WORD0,
      CFG_DELIM_WORD1,
      CFG_DELIM_WORD2,
      CFG_DELIM_WORD3,
      CFG_DELIM_LENGTH: known_idx = 1'b1;
      default:          known_idx = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DelimWords; k++) word_q[k] <= '0;
      len_q <= DelimLenReset;
    end else if (wr_en_i) begin
      case (cfg_index_e'(wr_index_i))
        CFG_DELIM_WORD0:  word_q[0] <= wr_data_i;
        CFG_DELIM_WORD1:  word_q[1] <= wr_data_i;
        CFG_DELIM_WORD2:  word_q[2] <= wr_data_i;
        CFG_DELIM_WORD3:  word_q[3] <= wr_data_i;
        CFG_DELIM_LENGTH: len_q     <= wr_data_i[DelimLenW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.delim        = {word_q[3], word_q[2], word_q[1], word_q[0]};
  assign cfg_o.delim_length = len_q;
  assign cfg_o.clear        = wr_en_i && known_idx;

endmodule

/* rtl/core/mps_scan.sv */
module mps_scan import mps_pkg::*; #(
  parameter int unsigned MAX_DELIM = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output logic has_res_o,
  output res_t res_o
);

  localparam int unsigned IdxW = $clog2(MAX_DELIM + 1);
  localparam int unsigned CntW = $clog2(MAX_DELIM + 2);

  logic [7:0]         win_q   [MAX_DELIM+1];
  logic [7:0]         win_new [MAX_DELIM+1];
  logic [IdxW-1:0]    hold_cnt_q, hold_cnt_d;
  logic [OffsetW-1:0] consumed_q, consumed_d;
  logic [CntW-1:0]    dlen, n;
  logic [MAX_DELIM-1:0] eq0, eq1, lt_dlen, lt_n, lt_nm1;
  logic match0, match1, match, prefix0, prefix1, is_cr, release_byte, shift;
  logic is_eom;

  // effective delimiter length: zero acts as one, clamp to MAX_DELIM
  always_comb begin
    if (cfg_i.delim_length == '0) begin
      dlen = CntW'(1);
    end else if (cfg_i.delim_length > DelimLenW'(MAX_DELIM)) begin
      dlen = CntW'(MAX_DELIM);
    end else begin
      dlen = CntW'(cfg_i.delim_length);
    end
  end

  assign n      = CntW'(hold_cnt_q) + CntW'(1);
  assign is_eom = (req_i.req_type == REQ_END_OF_MSG);

  always_comb begin
    for (int i = 0; i <= MAX_DELIM; i++) begin
      win_new[i] = (hold_cnt_q == IdxW'(i)) ? req_i.body_byte : win_q[i];
    end
    for (int i = 0; i < MAX_DELIM; i++) begin
      eq0[i]     = (win_new[i]   == cfg_i.delim[8*i +: 8]);
      eq1[i]     = (win_new[i+1] == cfg_i.delim[8*i +: 8]);
      lt_dlen[i] = (CntW'(i) < dlen);
      lt_n[i]    = (CntW'(i) < n);
      lt_nm1[i]  = (CntW'(i + 1) < n);
    end
  end

  assign match0  = (n == dlen) && (&(eq0 | ~lt_dlen));
  assign match1  = (n == dlen + CntW'(1)) && (&(eq1 | ~lt_dlen));
  assign match   = match0 || match1;
  assign is_cr   = (win_new[0] == CR_BYTE);
  assign prefix0 = (n <= dlen) && (&(eq0 | ~lt_n));
  assign prefix1 = &(eq1 | ~lt_nm1);
  assign shift   = !match && !prefix0 && !(is_cr && prefix1);
  // data byte ahead of a full-window match goes out with field end unless it is a carriage return
  assign release_byte = shift || (match1 && !is_cr);

  always_comb begin
    res_o = '0;
    has_res_o = 1'b0;
    hold_cnt_d = hold_cnt_q;
    consumed_d = consumed_q;
    if (is_eom) begin
      has_res_o = 1'b1;
      res_o.field_done = 1'b1;
      hold_cnt_d = '0;
    end else begin
      consumed_d = consumed_q + OffsetW'(1);
      if (match) begin
        has_res_o = 1'b1;
        res_o.field_done = 1'b1;
        res_o.delim_seen = 1'b1;
        hold_cnt_d = '0;
      end else if (shift) begin
        has_res_o = 1'b1;
      end else begin
        hold_cnt_d = IdxW'(n);
      end
      if (release_byte) begin
        res_o.out_valid = 1'b1;
        res_o.out_byte  = win_new[0];
      end
    end
    res_o.byte_offset = consumed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt_q <= '0;
      consumed_q <= '0;
    end else if (cfg_i.clear) begin
      hold_cnt_q <= '0;
    end else if (fire_i) begin
      hold_cnt_q <= hold_cnt_d;
      consumed_q <= consumed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !is_eom) begin
      for (int i = 0; i <= MAX_DELIM; i++) begin
        if (shift && i < MAX_DELIM) begin
          win_q[i] <= win_new[i+1];
        end else begin
          win_q[i] <= win_new[i];
        end
      end
    end
  end

  a_hold_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(hold_cnt_q) <= dlen)
    else $error("hold count exceeds delimiter length");

  a_body_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !is_eom && !cfg_i.clear) |=> consumed_q == $past(consumed_q) + OffsetW'(1))
    else $error("body byte not counted");

  a_eom_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_eom) |=> consumed_q == $past(consumed_q) && hold_cnt_q == '0)
    else $error("end of message disturbed count or window");

  a_match_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !cfg_i.clear && res_o.delim_seen) |=> hold_cnt_q == '0)
    else $error("window not cleared on delimiter");

endmodule

/* dv/mps_checker.sv */
module mps_checker import mps_pkg::*; #(
  parameter int unsigned MAX_DELIM = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  mps_req_if   req_i,
  mps_res_if   res_i,
  mps_cfg_if   cfg_i,
  output int   fails_o,
  output int   pending_o
);

  localparam int unsigned PrintCap = 100;

  logic [DelimBitsW-1:0] delim_q;
  logic [DelimLenW-1:0]  dlen_q;
  logic [7:0]            win_q [MAX_DELIM+1];
  int unsigned           held_q;
  logic [OffsetW-1:0]    consumed_q;
  res_t                  due_results [$];

  task automatic report_error(string msg);
    fails_o++;
    if (fails_o <= PrintCap) begin
      $display("mps_checker: %0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned active_span();
    int unsigned n;
    n = dlen_q;
    if (n == 0) begin
      n = 1;
    end
    if (n > MAX_DELIM) begin
      n = MAX_DELIM;
    end
    return n;
  endfunction

  // window bytes [start +: len] equal delimiter bytes [0 +: len]
  function automatic bit matches_delim(int unsigned start, int unsigned len, int unsigned span);
    if (len > span || start + len > MAX_DELIM + 1) begin
      return 1'b0;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (win_q[start+i] != delim_q[8*i +: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_window();
    for (int unsigned i = 0; i <= MAX_DELIM; i++) begin
      win_q[i] = 8'h00;
    end
    held_q = 0;
  endtask

  task automatic write_shadow(logic [CfgIndexW-1:0] idx, logic [DelimWordW-1:0] data);
    case (idx)
      CFG_DELIM_WORD0: delim_q[0*DelimWordW +: DelimWordW] = data;
      CFG_DELIM_WORD1: delim_q[1*DelimWordW +: DelimWordW] = data;
      CFG_DELIM_WORD2: delim_q[2*DelimWordW +: DelimWordW] = data;
      CFG_DELIM_WORD3: delim_q[3*DelimWordW +: DelimWordW] = data;
      CFG_DELIM_LENGTH: dlen_q = data[DelimLenW-1:0];
      default: return;
    endcase
    clear_window();
  endtask

  task automatic scan_item(logic kind, logic [7:0] data);
    res_t        r;
    int unsigned span;
    int unsigned n;
    bit          emit;
    span = active_span();
    r = '0;
    emit = 1'b1;
    if (kind == REQ_END_OF_MSG) begin
      clear_window();
      r.field_done = 1'b1;
    end else begin
      consumed_q++;
      if (held_q > span) begin
        clear_window();
      end
      win_q[held_q] = data;
      held_q++;
      n = held_q;
      if (n >= span && matches_delim(n - span, span, span)) begin
        if (n == span + 1 && win_q[0] != CR_BYTE) begin
          r.out_valid = 1'b1;
          r.out_byte  = win_q[0];
        end
        r.field_done = 1'b1;
        r.delim_seen = 1'b1;
        clear_window();
      end else if (!matches_delim(0, n, span) &&
                   !(win_q[0] == CR_BYTE && matches_delim(1, n - 1, span))) begin
        r.out_valid = 1'b1;
        r.out_byte  = win_q[0];
        for (int unsigned i = 0; i + 1 < n; i++) begin
          win_q[i] = win_q[i+1];
        end
        win_q[n-1] = 8'h00;
        held_q--;
      end else begin
        emit = 1'b0;
      end
    end
    r.byte_offset = consumed_q;
    if (emit) begin
      due_results.push_back(r);
    end
  endtask

  task automatic compare_field(string name, logic [OffsetW-1:0] got, logic [OffsetW-1:0] want,
                               logic [OffsetW-1:0] offset);
    if (got !== want) begin
      report_error($sformatf("%s got 0x%0h want 0x%0h (offset %0d)", name, got, want, offset));
    end
  endtask

  task automatic check_result();
    res_t want;
    if (due_results.size() == 0) begin
      report_error($sformatf("result with nothing due: out_valid %0b field_done %0b offset %0d",
                             res_i.out_valid, res_i.field_done, res_i.byte_offset));
      return;
    end
    want = due_results.pop_front();
    compare_field("out_valid", OffsetW'(res_i.out_valid), OffsetW'(want.out_valid),
                  want.byte_offset);
    compare_field("out_byte", OffsetW'(res_i.out_byte), OffsetW'(want.out_byte),
                  want.byte_offset);
    compare_field("field_done", OffsetW'(res_i.field_done), OffsetW'(want.field_done),
                  want.byte_offset);
    compare_field("delim_seen", OffsetW'(res_i.delim_seen), OffsetW'(want.delim_seen),
                  want.byte_offset);
    compare_field("byte_offset", res_i.byte_offset, want.byte_offset, want.byte_offset);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q = '0;
      dlen_q = DelimLenReset;
      clear_window();
      consumed_q = '0;
      due_results.delete();
      pending_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        check_result();
      end
      if (cfg_i.valid && cfg_i.ready) begin
        write_shadow(cfg_i.index, cfg_i.data);
      end
      if (req_i.valid && req_i.ready) begin
        scan_item(req_i.req_type, req_i.body_byte);
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import mps_pkg::*;

  localparam int unsigned MaxDelim      = 32;
  localparam int unsigned Phases        = 8;
  localparam int unsigned PhaseItems    = 225;
  localparam int unsigned QuietPhase    = 1;
  localparam int unsigned PressurePhase = 4;
  localparam int unsigned UnmappedPhase = 5;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned StallCycles   = 300;
  localparam int unsigned CycleLimit    = 200000;
  localparam logic [CfgIndexW-1:0] CfgUnmapped = 3'd7;
  localparam logic [7:0] LF_BYTE = 8'h0A;

  logic clk_i;
  logic rst_ni;
  int   fails;
  int   pending;

  logic [7:0]  pat [MaxDelim];
  int unsigned span;
  int unsigned sent;
  bit          quiet_q;
  bit          squeeze_q;
  bit          squeezed;
  int unsigned hold_left;
  int unsigned cycles;

  mps_req_if req_if();
  mps_res_if res_if();
  mps_cfg_if cfg_if();

  multipart_boundary_scanner #(
    .MAX_DELIM(MaxDelim)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  mps_checker #(
    .MAX_DELIM(MaxDelim)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_if),
    .res_i    (res_if),
    .cfg_i    (cfg_if),
    .fails_o  (fails),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: random back-pressure (none in the quiet phase) plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    squeezed = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (squeeze_q && !squeezed) begin
        squeezed = 1'b1;
        hold_left = StallCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= quiet_q || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_req(req_type_e kind, logic [7:0] data);
    while (!quiet_q && $urandom_range(99) < 20) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.body_byte <= data;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [DelimWordW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  task automatic finish_phase();
    req_if.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic load_delim(logic [DelimBitsW-1:0] bits, logic [DelimLenW-1:0] len_raw);
    write_reg(CFG_DELIM_WORD0, bits[0*DelimWordW +: DelimWordW]);
    write_reg(CFG_DELIM_WORD1, bits[1*DelimWordW +: DelimWordW]);
    write_reg(CFG_DELIM_WORD2, bits[2*DelimWordW +: DelimWordW]);
    write_reg(CFG_DELIM_WORD3, bits[3*DelimWordW +: DelimWordW]);
    write_reg(CFG_DELIM_LENGTH, DelimWordW'(len_raw));
    cfg_if.valid <= 1'b0;
    for (int unsigned i = 0; i < MaxDelim; i++) begin
      pat[i] = bits[8*i +: 8];
    end
    span = (len_raw == 0) ? 1 : ((len_raw > MaxDelim) ? MaxDelim : len_raw);
  endtask

  function automatic logic [DelimBitsW-1:0] rand_delim(bit narrow);
    logic [DelimBitsW-1:0] bits;
    for (int unsigned i = 0; i < MaxDelim; i++) begin
      if (!narrow) begin
        bits[8*i +: 8] = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0: bits[8*i +: 8] = 8'h61;
          1: bits[8*i +: 8] = 8'h62;
          2: bits[8*i +: 8] = CR_BYTE;
          default: bits[8*i +: 8] = LF_BYTE;
        endcase
      end
    end
    return bits;
  endfunction

  function automatic logic [7:0] stream_byte();
    case ($urandom_range(3))
      0: return pat[$urandom_range(span - 1)];
      1: return CR_BYTE;
      2: return LF_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one field: random body with partial and broken delimiter runs, then usually its end (a delimiter or end of message)
  task automatic send_field();
    int unsigned cut;
    int unsigned k;
    repeat ($urandom_range(5)) begin
      case ($urandom_range(5))
        0: send_req(REQ_BODY_BYTE, 8'($urandom_range(255)));
        1: send_req(REQ_BODY_BYTE, pat[$urandom_range(span - 1)]);
        2: send_req(REQ_BODY_BYTE, CR_BYTE);
        3: begin
          cut = $urandom_range(span - 1);
          for (int unsigned j = 0; j < cut; j++) begin
            send_req(REQ_BODY_BYTE, pat[j]);
          end
          if ($urandom_range(1) == 1) begin
            send_req(REQ_BODY_BYTE, stream_byte());
          end
        end
        4: repeat ($urandom_range(1, 4)) send_req(REQ_BODY_BYTE, stream_byte());
        default: begin
          if ($urandom_range(19) == 0) begin
            send_req(REQ_END_OF_MSG, 8'($urandom_range(255)));
          end else begin
            send_req(REQ_BODY_BYTE, 8'($urandom_range(255)));
          end
        end
      endcase
    end
    k = $urandom_range(9);
    if (k < 6) begin
      if ($urandom_range(1) == 1) begin
        send_req(REQ_BODY_BYTE, CR_BYTE);
      end
      for (int unsigned j = 0; j < span; j++) begin
        send_req(REQ_BODY_BYTE, pat[j]);
      end
    end else if (k < 9) begin
      send_req(REQ_END_OF_MSG, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [DelimBitsW-1:0] bits;
    logic [DelimLenW-1:0]  len_raw;
    int unsigned           stop_at;
    bit                    poked;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_BODY_BYTE;
    req_if.body_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DELIM_WORD0;
    cfg_if.data = '0;
    quiet_q = 1'b0;
    squeeze_q = 1'b0;
    poked = 1'b0;
    sent = 0;
    span = 1;
    for (int unsigned i = 0; i < MaxDelim; i++) begin
      pat[i] = 8'h00;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset delimiter: single zero byte
    send_req(REQ_BODY_BYTE, 8'h00);
    send_req(REQ_BODY_BYTE, 8'hFF);
    send_req(REQ_BODY_BYTE, CR_BYTE);
    send_req(REQ_BODY_BYTE, 8'h00);
    send_req(REQ_BODY_BYTE, CR_BYTE);
    send_req(REQ_BODY_BYTE, 8'h41);
    send_req(REQ_BODY_BYTE, 8'h80);
    send_req(REQ_END_OF_MSG, 8'hFF);
    finish_phase();

    // "ab": backlog after a broken match, then match with a data byte ahead
    load_delim(DelimBitsW'(16'h6261), DelimLenW'(2));
    send_req(REQ_BODY_BYTE, CR_BYTE);
    send_req(REQ_BODY_BYTE, 8'h61);
    send_req(REQ_BODY_BYTE, CR_BYTE);
    send_req(REQ_BODY_BYTE, 8'h78);
    send_req(REQ_BODY_BYTE, 8'h61);
    send_req(REQ_BODY_BYTE, 8'h62);
    send_req(REQ_BODY_BYTE, 8'h61);
    send_req(REQ_END_OF_MSG, 8'h00);
    send_req(REQ_BODY_BYTE, CR_BYTE);
    send_req(REQ_BODY_BYTE, 8'h61);
    send_req(REQ_BODY_BYTE, 8'h62);
    finish_phase();

    for (int unsigned p = 0; p < Phases; p++) begin
      quiet_q <= (p == QuietPhase);
      squeeze_q <= (p == PressurePhase);
      case (p)
        0: begin
          bits = rand_delim(1'b0);
          len_raw = DelimLenW'(0);
        end
        1: begin
          bits = rand_delim(1'b0);
          bits[55:0] = 56'h7A_3942_412D_2D0A;
          len_raw = DelimLenW'(7);
        end
        2: begin
          bits = '1;
          len_raw = '1;
        end
        3: begin
          bits = '0;
          len_raw = DelimLenW'(MaxDelim);
        end
        4: begin
          bits = rand_delim(1'b0);
          bits[31:0] = 32'h0A0D_0A0D;
          len_raw = DelimLenW'(4);
        end
        5: begin
          bits = rand_delim(1'b1);
          len_raw = DelimLenW'($urandom_range(2, 8));
        end
        6: begin
          bits = rand_delim(1'b0);
          len_raw = DelimLenW'(MaxDelim + 1);
        end
        default: begin
          bits = rand_delim(1'b1);
          len_raw = DelimLenW'(1);
        end
      endcase
      load_delim(bits, len_raw);
      stop_at = sent + PhaseItems;
      while (sent < stop_at) begin
        send_field();
        if (p == UnmappedPhase && sent >= stop_at - PhaseItems / 2 && !poked) begin
          // write to an unmapped index mid-stream; must leave held bytes alone
          finish_phase();
          write_reg(CfgUnmapped, {$urandom, $urandom});
          cfg_if.valid <= 1'b0;
          poked = 1'b1;
        end
      end
      finish_phase();
    end

    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
